>>> sv/sbfa_pkg.sv
// shared types, constants and state codes of the spectrum bar fall-off block
package sbfa_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int SLOT_W     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_GAIN    = 1'd1;

    localparam logic [15:0] DECAY_RESET = 16'd50463;
    localparam logic [31:0] SENS_RESET  = 32'd65536;
    localparam logic [16:0] FULL_SCALE  = 17'd65536;

    // 65537 * 100000: first product whose level exceeds full scale
    localparam logic [63:0] OVER_LIMIT = 64'd6553700000;
    // 100000 = 32 * 3125, quotient by 3125 through a reciprocal of 2^40 / 3125
    localparam logic [28:0] RECIP_M = 29'd351843720;
    localparam logic [11:0] DIV_LOW = 12'd3125;

    localparam logic [24:0] K_SHRINK = 25'd16525558;
    localparam logic [24:0] K_GROW   = 25'd16794001;
    localparam logic [24:0] K_WARM   = 25'd18454938;
    localparam logic [57:0] GAIN_ROUND = 58'd8388608;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic [5:0]  bar_number;
        logic [31:0] raw_energy;
        logic        frame_silent;
        logic        frame_end;
    } sbfa_in_t;

    typedef struct packed {
        logic [5:0]  bar_out;
        logic [16:0] bar_level;
        logic        frame_done;
    } sbfa_out_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [5:0]        bar_number;
        logic [31:0]       raw_energy;
        logic              frame_silent;
        logic              frame_end;
    } sbfa_item_t;

    typedef struct packed {
        logic [15:0] decay_factor;
        logic        auto_gain_enable;
    } sbfa_cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECAY,
        ST_MAX,
        ST_SCALE,
        ST_RECIP,
        ST_CORR,
        ST_EMIT,
        ST_GAIN_MUL,
        ST_GAIN_RND
    } sbfa_state_t;

endpackage

>>> sv/sbfa_front.sv
// front end: configuration registers, store slot selection and queue push
module sbfa_front #(
    parameter int MAX_BARS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [sbfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sbfa_pkg::sbfa_in_t             s_data,
    output sbfa_pkg::sbfa_cfg_t            cfg,
    output logic                           push_valid,
    input  logic                           push_ready,
    output sbfa_pkg::sbfa_item_t           push_item
);

    logic [15:0] decay_reg;
    logic        gain_en_reg;
    logic [16:0] rem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg   <= sbfa_pkg::DECAY_RESET;
            gain_en_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sbfa_pkg::CFG_DECAY_FACTOR: decay_reg   <= cfg_wdata;
                sbfa_pkg::CFG_AUTO_GAIN:    gain_en_reg <= cfg_wdata[0];
            endcase
        end
    end

    // bar number reduced modulo the store depth, one restoring step per bit
    always_comb begin
        rem = {11'd0, s_data.bar_number};
        for (int i = 5; i >= 0; i--) begin
            if (rem >= (17'(MAX_BARS) << i)) begin
                rem = rem - (17'(MAX_BARS) << i);
            end
        end
    end

    assign cfg.decay_factor     = decay_reg;
    assign cfg.auto_gain_enable = gain_en_reg;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    assign push_item.slot         = rem[sbfa_pkg::SLOT_W-1:0];
    assign push_item.bar_number   = s_data.bar_number;
    assign push_item.raw_energy   = s_data.raw_energy;
    assign push_item.frame_silent = s_data.frame_silent;
    assign push_item.frame_end    = s_data.frame_end;

endmodule

>>> sv/sbfa_queue.sv
// two-entry queue between front end and back end
module sbfa_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  sbfa_pkg::sbfa_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output sbfa_pkg::sbfa_item_t pop_item
);

    sbfa_pkg::sbfa_item_t ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != sbfa_pkg::QUEUE_DEPTH);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = ent_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/sbfa_back.sv
// back end: smoothed store, level scaling, output register and gain update
module sbfa_back #(
    parameter int MAX_BARS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sbfa_pkg::sbfa_cfg_t  cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  sbfa_pkg::sbfa_item_t q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sbfa_pkg::sbfa_out_t  m_data
);

    localparam int ADDR_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BARS - 1);

    sbfa_pkg::sbfa_state_t state_reg, state_next;

    logic [ADDR_W-1:0]    clr_cnt_reg;
    sbfa_pkg::sbfa_item_t item_reg;
    logic [31:0]          mem [MAX_BARS];
    logic [31:0]          rd_data_reg;
    logic [47:0]          dec_prod_reg;
    logic [31:0]          val_reg;
    logic [63:0]          lvl_prod_reg;
    logic                 over_reg;
    logic [27:0]          x_reg;
    logic [56:0]          rcp_prod_reg;
    logic [16:0]          q_reg;
    logic [28:0]          qm_reg;
    logic [31:0]          sens_reg;
    logic                 warmup_reg;
    logic                 overshoot_reg;
    logic [24:0]          gain_k_reg;
    logic                 warm_pending_reg;
    logic [56:0]          gain_prod_reg;
    logic                 m_valid_reg;
    sbfa_pkg::sbfa_out_t  m_data_reg;

    logic              out_free;
    logic              q_pop;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [31:0]       mem_wdata;
    logic              out_load;
    logic [31:0]       decayed;
    logic [31:0]       val_max;
    logic [28:0]       rem;
    logic [16:0]       q_fix;
    logic [16:0]       level;
    logic              frame_over;
    logic [57:0]       gain_sum;
    logic [31:0]       gain_sat;

    assign out_free   = !m_valid_reg || m_ready;
    assign decayed    = dec_prod_reg[47:16];
    assign val_max    = (item_reg.raw_energy > decayed) ? item_reg.raw_energy : decayed;
    assign rem        = {1'b0, x_reg} - qm_reg;
    assign q_fix      = (rem >= 29'(sbfa_pkg::DIV_LOW)) ? q_reg + 17'd1 : q_reg;
    assign level      = over_reg ? sbfa_pkg::FULL_SCALE : q_fix;
    assign frame_over = overshoot_reg || over_reg;
    assign gain_sum   = 58'(gain_prod_reg) + sbfa_pkg::GAIN_ROUND;
    assign gain_sat   = (gain_sum[57:56] != 2'd0) ? 32'hFFFF_FFFF : gain_sum[55:24];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbfa_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = sbfa_pkg::ST_IDLE;
                end
            end
            sbfa_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = sbfa_pkg::ST_DECAY;
                end
            end
            sbfa_pkg::ST_DECAY: state_next = sbfa_pkg::ST_MAX;
            sbfa_pkg::ST_MAX:   state_next = sbfa_pkg::ST_SCALE;
            sbfa_pkg::ST_SCALE: state_next = sbfa_pkg::ST_RECIP;
            sbfa_pkg::ST_RECIP: state_next = sbfa_pkg::ST_CORR;
            sbfa_pkg::ST_CORR:  state_next = sbfa_pkg::ST_EMIT;
            sbfa_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (item_reg.frame_end && cfg.auto_gain_enable &&
                        (frame_over || !item_reg.frame_silent)) begin
                        state_next = sbfa_pkg::ST_GAIN_MUL;
                    end else begin
                        state_next = sbfa_pkg::ST_IDLE;
                    end
                end
            end
            sbfa_pkg::ST_GAIN_MUL: state_next = sbfa_pkg::ST_GAIN_RND;
            sbfa_pkg::ST_GAIN_RND: begin
                state_next = warm_pending_reg ? sbfa_pkg::ST_GAIN_MUL : sbfa_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        q_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = item_reg.slot[ADDR_W-1:0];
        mem_wdata = val_max;
        out_load  = 1'b0;
        unique case (state_reg)
            sbfa_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            sbfa_pkg::ST_IDLE: q_ready  = 1'b1;
            sbfa_pkg::ST_MAX:  mem_we   = 1'b1;
            sbfa_pkg::ST_EMIT: out_load = out_free;
            default: ;
        endcase
    end

    assign q_pop = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            rd_data_reg <= mem[q_item.slot[ADDR_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= sbfa_pkg::ST_CLEAR;
            clr_cnt_reg      <= '0;
            sens_reg         <= sbfa_pkg::SENS_RESET;
            warmup_reg       <= 1'b1;
            overshoot_reg    <= 1'b0;
            warm_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sbfa_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (out_load) begin
                if (item_reg.frame_end) begin
                    overshoot_reg <= 1'b0;
                    if (cfg.auto_gain_enable) begin
                        if (frame_over) begin
                            warmup_reg       <= 1'b0;
                            warm_pending_reg <= 1'b0;
                        end else if (!item_reg.frame_silent) begin
                            warm_pending_reg <= warmup_reg;
                        end
                    end
                end else begin
                    overshoot_reg <= frame_over;
                end
            end
            if (state_reg == sbfa_pkg::ST_GAIN_RND) begin
                sens_reg         <= gain_sat;
                warm_pending_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        unique case (state_reg)
            sbfa_pkg::ST_DECAY: dec_prod_reg <= 48'(rd_data_reg) * 48'(cfg.decay_factor);
            sbfa_pkg::ST_MAX:   val_reg      <= val_max;
            sbfa_pkg::ST_SCALE: lvl_prod_reg <= 64'(val_reg) * 64'(sens_reg);
            sbfa_pkg::ST_RECIP: begin
                over_reg     <= (lvl_prod_reg >= sbfa_pkg::OVER_LIMIT);
                x_reg        <= lvl_prod_reg[32:5];
                rcp_prod_reg <= 57'(lvl_prod_reg[32:5]) * 57'(sbfa_pkg::RECIP_M);
            end
            sbfa_pkg::ST_CORR: begin
                q_reg  <= rcp_prod_reg[56:40];
                qm_reg <= 29'(rcp_prod_reg[56:40]) * 29'(sbfa_pkg::DIV_LOW);
            end
            sbfa_pkg::ST_EMIT: begin
                if (out_load) begin
                    m_data_reg.bar_out    <= item_reg.bar_number;
                    m_data_reg.bar_level  <= level;
                    m_data_reg.frame_done <= item_reg.frame_end;
                    if (frame_over) begin
                        gain_k_reg <= sbfa_pkg::K_SHRINK;
                    end else begin
                        gain_k_reg <= sbfa_pkg::K_GROW;
                    end
                end
            end
            sbfa_pkg::ST_GAIN_MUL: gain_prod_reg <= 57'(sens_reg) * 57'(gain_k_reg);
            sbfa_pkg::ST_GAIN_RND: gain_k_reg    <= sbfa_pkg::K_WARM;
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/spectrum_bar_falloff_agc.sv
// top level of the spectrum bar fall-off block with automatic gain
// a bar is queued, then steps through the back-end decay, max, scale, reciprocal,
// correction and emit states, one bar at a time; gain update at frame end adds
// the gain multiply and round states, repeated with the warm-up factor during warm-up growth
// reset: synchronous active-low; then a store clearing pass of MAX_BARS entries,
// during which up to two transactions are queued but not processed
module spectrum_bar_falloff_agc #(
    parameter int MAX_BARS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sbfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sbfa_pkg::sbfa_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sbfa_pkg::sbfa_out_t             m_data
);

    sbfa_pkg::sbfa_cfg_t  cfg;
    logic                 push_valid;
    logic                 push_ready;
    sbfa_pkg::sbfa_item_t push_item;
    logic                 pop_valid;
    logic                 pop_ready;
    sbfa_pkg::sbfa_item_t pop_item;

    sbfa_front #(
        .MAX_BARS(MAX_BARS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    sbfa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    sbfa_back #(
        .MAX_BARS(MAX_BARS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_item  (pop_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> sv/sbfa_checker.sv
// port-level checker for the spectrum bar fall-off block and its bind
module sbfa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sbfa_pkg::sbfa_out_t m_data
);

    // stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // level never above full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.bar_level <= sbfa_pkg::FULL_SCALE)
        else $error("bar level above full scale");

    // reset clears the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // queue is empty and ready straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind spectrum_bar_falloff_agc sbfa_checker u_sbfa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> sim/tb.sv
// testbench for spectrum_bar_falloff_agc: predicted bar levels checked against every result
module tb;

    typedef enum int {RX_FREE, RX_COIN, RX_CADENCE, RX_SPARSE} rx_mode_t;

    class level_scoreboard;
        logic [31:0] smoothed [64];
        logic [31:0] sens;
        bit          warmup;
        bit          overshoot;
        logic [15:0] decay;
        bit          gain_on;
        sbfa_pkg::sbfa_out_t pending_levels [$];
        int          fails;

        function new();
            foreach (smoothed[i]) smoothed[i] = 32'd0;
            sens      = sbfa_pkg::SENS_RESET;
            warmup    = 1'b1;
            overshoot = 1'b0;
            decay     = sbfa_pkg::DECAY_RESET;
            gain_on   = 1'b1;
            fails     = 0;
        endfunction

        function void write_reg(logic [sbfa_pkg::CFG_IDX_W-1:0] idx,
                                logic [sbfa_pkg::CFG_DATA_W-1:0] value);
            if (idx == sbfa_pkg::CFG_DECAY_FACTOR) begin
                decay = value;
            end else if (idx == sbfa_pkg::CFG_AUTO_GAIN) begin
                gain_on = value[0];
            end
        endfunction

        function logic [31:0] scale_gain(logic [31:0] s, logic [24:0] k);
            logic [63:0] p;
            p = (64'(s) * 64'(k) + 64'd8388608) >> 24;
            if (p > 64'hFFFF_FFFF) begin
                p = 64'hFFFF_FFFF;
            end
            return p[31:0];
        endfunction

        function void note_bar(sbfa_pkg::sbfa_in_t it);
            logic [47:0] prod;
            logic [31:0] decayed;
            logic [31:0] held;
            logic [63:0] lvl;
            sbfa_pkg::sbfa_out_t exp_level;
            prod    = 48'(smoothed[it.bar_number]) * 48'(decay);
            decayed = prod[47:16];
            held    = (it.raw_energy > decayed) ? it.raw_energy : decayed;
            smoothed[it.bar_number] = held;
            lvl = (64'(held) * 64'(sens)) / 64'd100000;
            if (lvl > 64'(sbfa_pkg::FULL_SCALE)) begin
                overshoot = 1'b1;
                lvl = 64'(sbfa_pkg::FULL_SCALE);
            end
            exp_level.bar_out    = it.bar_number;
            exp_level.bar_level  = lvl[16:0];
            exp_level.frame_done = it.frame_end;
            pending_levels.push_back(exp_level);
            if (it.frame_end) begin
                if (gain_on) begin
                    if (overshoot) begin
                        sens   = scale_gain(sens, sbfa_pkg::K_SHRINK);
                        warmup = 1'b0;
                    end else if (!it.frame_silent) begin
                        sens = scale_gain(sens, sbfa_pkg::K_GROW);
                        if (warmup) begin
                            sens = scale_gain(sens, sbfa_pkg::K_WARM);
                        end
                    end
                end
                overshoot = 1'b0;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fails++;
        endtask

        task check_level(sbfa_pkg::sbfa_out_t got);
            sbfa_pkg::sbfa_out_t want;
            if (pending_levels.size() == 0) begin
                report($sformatf("unexpected transaction bar %0d level %0d",
                                 got.bar_out, got.bar_level));
            end else begin
                want = pending_levels.pop_front();
                if (got.bar_out !== want.bar_out) begin
                    report($sformatf("bar_out %0d, want %0d", got.bar_out, want.bar_out));
                end
                if (got.bar_level !== want.bar_level) begin
                    report($sformatf("bar %0d level %0d, want %0d",
                                     want.bar_out, got.bar_level, want.bar_level));
                end
                if (got.frame_done !== want.frame_done) begin
                    report($sformatf("bar %0d frame_done %0b, want %0b",
                                     want.bar_out, got.frame_done, want.frame_done));
                end
            end
        endtask
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_we;
    logic [sbfa_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [sbfa_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    sbfa_pkg::sbfa_in_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    sbfa_pkg::sbfa_out_t             m_data;

    level_scoreboard board;
    bit              hold_request;
    bit              sender_live;
    int              burst_left;

    spectrum_bar_falloff_agc #(.MAX_BARS(64)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic sbfa_pkg::sbfa_in_t make_bar(logic [5:0] bar, logic [31:0] raw,
                                                    bit silent, bit last);
        sbfa_pkg::sbfa_in_t it;
        it.bar_number   = bar;
        it.raw_energy   = raw;
        it.frame_silent = silent;
        it.frame_end    = last;
        return it;
    endfunction

    // energies cluster around the level where the bar just reaches full scale
    function automatic logic [31:0] pick_energy(logic [31:0] sens);
        logic [63:0] thr;
        logic [63:0] hi;
        logic [31:0] t;
        logic [31:0] r;
        thr = 64'd6553600000 / ((sens == 32'd0) ? 64'd1 : 64'(sens));
        if (thr > 64'hFFFF_FFFF) begin
            thr = 64'hFFFF_FFFF;
        end
        t  = thr[31:0];
        hi = thr + thr / 4;
        if (hi > 64'hFFFF_FFFF) begin
            hi = 64'hFFFF_FFFF;
        end
        case ($urandom_range(0, 9))
            0: r = 32'd0;
            1: r = $urandom;
            2: r = $urandom_range(0, t / 4);
            3: r = $urandom_range((t == 0) ? 0 : t - 1, (t == 32'hFFFF_FFFF) ? t : t + 1);
            default: r = $urandom_range(t / 2, hi[31:0]);
        endcase
        return r;
    endfunction

    task send_bar(sbfa_pkg::sbfa_in_t it);
        int gap;
        s_data  <= it;
        s_valid <= 1'b1;
        sender_live = 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_bar(it);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                sender_live = 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task drain();
        if (sender_live) begin
            s_valid <= 1'b0;
            sender_live = 1'b0;
        end
        while (board.pending_levels.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task set_config(logic [15:0] decay, bit gain);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= sbfa_pkg::CFG_DECAY_FACTOR;
        cfg_wdata <= decay;
        @(posedge aclk);
        cfg_index <= sbfa_pkg::CFG_AUTO_GAIN;
        cfg_wdata <= {15'd0, gain};
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.write_reg(sbfa_pkg::CFG_DECAY_FACTOR, decay);
        board.write_reg(sbfa_pkg::CFG_AUTO_GAIN, {15'd0, gain});
    endtask

    task run_frames(int count);
        int sent;
        int len;
        int start;
        bit ordered;
        logic [5:0] bar;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_bar(make_bar(6'($urandom), $urandom, 1'($urandom), 1'($urandom)));
                sent++;
            end else begin
                len     = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                      : $urandom_range(1, 16);
                start   = $urandom_range(0, 63);
                ordered = ($urandom_range(0, 3) != 0);
                for (int i = 0; i < len; i++) begin
                    bar = ordered ? 6'((start + i) % 64) : 6'($urandom);
                    if (i == len - 1) begin
                        send_bar(make_bar(bar, pick_energy(board.sens),
                                          $urandom_range(0, 4) == 0, 1'b1));
                    end else begin
                        send_bar(make_bar(bar, pick_energy(board.sens), 1'($urandom), 1'b0));
                    end
                end
                sent += len;
            end
        end
    endtask

    // receiver: changing stall patterns plus an occasional long hold-off
    initial begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       hold;
        int       cyc;
        mode      = RX_FREE;
        mode_left = 0;
        hold      = 0;
        cyc       = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_level(m_data);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold = 400;
            end
            cyc++;
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_FREE:    m_ready <= 1'b1;
                    RX_COIN:    m_ready <= 1'($urandom);
                    RX_CADENCE: m_ready <= (cyc % 4 != 0);
                    default:    m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] decays [6];
        bit          gains  [6];
        board        = new();
        hold_request = 1'b0;
        sender_live  = 1'b0;
        burst_left   = 1;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= sbfa_pkg::CFG_DECAY_FACTOR;
        cfg_wdata <= 16'd0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_config(sbfa_pkg::DECAY_RESET, 1'b1);

        // warm-up growth on quiet frames drives sensitivity into saturation
        repeat (160) begin
            send_bar(make_bar(6'($urandom), 32'd0, $urandom_range(0, 7) == 0, 1'b1));
        end

        send_bar(make_bar(6'd0, 32'd0, 1'b0, 1'b0));
        send_bar(make_bar(6'd63, 32'd1, 1'b1, 1'b0));
        send_bar(make_bar(6'd5, 32'hFFFF_FFFF, 1'b0, 1'b0));
        send_bar(make_bar(6'd5, 32'd0, 1'b0, 1'b1));
        send_bar(make_bar(6'd63, 32'd0, 1'b1, 1'b1));
        send_bar(make_bar(6'd10, 32'd2, 1'b0, 1'b1));
        send_bar(make_bar(6'd11, 32'd1, 1'b0, 1'b1));
        send_bar(make_bar(6'd42, 32'h5555_5555, 1'b1, 1'b0));
        send_bar(make_bar(6'd21, 32'hAAAA_AAAA, 1'b0, 1'b1));

        set_config(sbfa_pkg::DECAY_RESET, 1'b0);
        send_bar(make_bar(6'd20, 32'hFFFF_FFFF, 1'b0, 1'b1));
        send_bar(make_bar(6'd22, 32'd0, 1'b0, 1'b1));

        set_config(16'd0, 1'b1);
        send_bar(make_bar(6'd5, 32'd0, 1'b0, 1'b0));
        send_bar(make_bar(6'd5, 32'd7, 1'b0, 1'b1));

        set_config(16'hFFFF, 1'b1);
        send_bar(make_bar(6'd5, 32'd0, 1'b0, 1'b1));
        send_bar(make_bar(6'd20, 32'd0, 1'b1, 1'b1));

        decays = '{16'd0, 16'hFFFF, 16'($urandom), sbfa_pkg::DECAY_RESET, 16'($urandom),
                   16'hFFFF};
        gains  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        for (int p = 0; p < 6; p++) begin
            set_config(decays[p], gains[p]);
            if (p == 1 || p == 4) begin
                hold_request = 1'b1;
            end
            run_frames(240);
        end

        drain();
        if (board.pending_levels.size() != 0) begin
            board.report("expected levels left over");
        end
        if (board.fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> filelist.f
sv/sbfa_pkg.sv
sv/sbfa_front.sv
sv/sbfa_queue.sv
sv/sbfa_back.sv
sv/spectrum_bar_falloff_agc.sv
sv/sbfa_checker.sv
sim/tb.sv
